// ----- rtl/serial_command_line_parser_macros.svh -----
// assertion macros for the serial command line parser checker
// needs aclk and aresetn in the scope where a macro is used
`ifndef SERIAL_COMMAND_LINE_PARSER_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_MACROS_SVH

// checked only outside reset
`define SCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked during reset too
`define SCL_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/scl_pkg.sv -----
// shared types and constants for the serial command line parser
// no dependencies
package scl_pkg;

    localparam int MAX_DIGITS_DEFAULT = 4;

    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_ECHO   = 8'h65;
    localparam logic [7:0]  CH_POWER  = 8'h70;
    localparam logic [13:0] NUM_LIMIT = 14'd9999;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SYNTAX  = 2'd1;
    localparam logic [1:0] EV_UNKNOWN = 2'd2;
    localparam logic [1:0] EV_KNOWN   = 2'd3;

    typedef enum logic [1:0] {
        MODE_DIGITS,
        MODE_LETTER,
        MODE_ERROR,
        MODE_RETURN
    } mode_t;

    typedef struct packed {
        logic       is_digit;
        logic       is_letter;
        logic       is_cr;
        logic       is_skip;
        logic [3:0] digit;
    } char_class_t;

endpackage

// ----- rtl/scl_char_class.sv -----
// character classifier for the serial command line parser
// depends on scl_pkg
module scl_char_class (
    input  logic [7:0]          rx_byte,
    output scl_pkg::char_class_t cls
);

    always_comb begin
        cls.is_digit  = (rx_byte >= scl_pkg::CH_ZERO) && (rx_byte <= scl_pkg::CH_NINE);
        cls.is_letter = ((rx_byte >= 8'h61) && (rx_byte <= 8'h7A)) ||
                        ((rx_byte >= 8'h41) && (rx_byte <= 8'h5A));
        cls.is_cr     = (rx_byte == scl_pkg::CH_CR);
        cls.is_skip   = (rx_byte == scl_pkg::CH_LF) || (rx_byte == scl_pkg::CH_SPACE);
        cls.digit     = rx_byte[3:0];
    end

endmodule

// ----- rtl/serial_command_line_parser.sv -----
// top level of the serial command line parser
// depends on scl_pkg and scl_char_class
//
// One received byte in, one result out per transfer, at a sustained rate of one byte
// per clock while m_ready stays high. A byte passes an input register, then the parser
// state and the result registers are updated together from it, and the result is offered
// from those registers. While a result waits on m_ready a byte in the input register holds
// and s_ready drops. Lines are up to MAX_DIGITS decimal digits, a letter and CR; events are
// reported on the CR. The echo flag shown with each result is the value before that byte.
module serial_command_line_parser #(
    parameter int MAX_DIGITS = scl_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_echo_out,
    output logic [1:0]  m_event_code,
    output logic [7:0]  m_command_letter,
    output logic [13:0] m_command_number,
    output logic        m_number_present
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                m_valid_reg, m_valid_next;
    logic                advance;

    scl_pkg::mode_t      mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [13:0]         number_reg, number_next;
    logic                seen_reg, seen_next;
    logic [7:0]          letter_reg, letter_next;
    logic                echo_reg, echo_next;

    logic [1:0]          event_reg, event_next;
    logic [7:0]          cmd_letter_reg, cmd_letter_next;
    logic [13:0]         cmd_number_reg, cmd_number_next;
    logic                present_reg, present_next;
    logic                echo_out_reg;

    scl_pkg::char_class_t cls;
    logic [17:0]         num_ext;
    logic [17:0]         num_times10;

    function automatic logic letter_is_known(input logic [7:0] c);
        return (c == scl_pkg::CH_POWER) || (c == 8'h61) || (c == 8'h76) ||
               (c == 8'h56) || (c == 8'h73) || (c == 8'h75) || (c == 8'h77) ||
               (c == 8'h63) || (c == 8'h53) || (c == 8'h43) ||
               (c == scl_pkg::CH_ECHO);
    endfunction

    scl_char_class u_char_class (
        .rx_byte (in_byte_reg),
        .cls     (cls)
    );

    assign advance       = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign m_valid_next  = advance || (m_valid_reg && !m_ready);

    assign num_ext     = {4'b0, number_reg};
    assign num_times10 = (num_ext << 3) + (num_ext << 1) + {14'b0, cls.digit};

    // next state
    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        number_next = number_reg;
        seen_next   = seen_reg;
        letter_next = letter_reg;
        echo_next   = echo_reg;
        case (mode_reg)
            scl_pkg::MODE_DIGITS: begin
                if (cls.is_digit) begin
                    if (num_times10 > {4'b0, scl_pkg::NUM_LIMIT}) begin
                        number_next = scl_pkg::NUM_LIMIT;
                    end else begin
                        number_next = num_times10[13:0];
                    end
                    seen_next  = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg == CNT_W'(MAX_DIGITS - 1)) begin
                        mode_next = scl_pkg::MODE_LETTER;
                    end
                end else if (cls.is_letter) begin
                    letter_next = in_byte_reg;
                    mode_next   = scl_pkg::MODE_RETURN;
                end else if (cls.is_skip) begin
                    mode_next = mode_reg;
                end else if (cls.is_cr) begin
                    mode_next   = scl_pkg::MODE_DIGITS;
                    count_next  = '0;
                    number_next = '0;
                    seen_next   = 1'b0;
                end else begin
                    mode_next = scl_pkg::MODE_ERROR;
                end
            end
            scl_pkg::MODE_LETTER: begin
                if (cls.is_letter) begin
                    letter_next = in_byte_reg;
                    mode_next   = scl_pkg::MODE_RETURN;
                end else begin
                    mode_next = scl_pkg::MODE_ERROR;
                end
            end
            scl_pkg::MODE_ERROR: begin
                if (cls.is_cr) begin
                    mode_next   = scl_pkg::MODE_DIGITS;
                    count_next  = '0;
                    number_next = '0;
                    seen_next   = 1'b0;
                end
            end
            scl_pkg::MODE_RETURN: begin
                if (cls.is_cr) begin
                    if (letter_reg == scl_pkg::CH_ECHO) begin
                        echo_next = seen_reg && (number_reg == 14'd1);
                    end
                    mode_next   = scl_pkg::MODE_DIGITS;
                    count_next  = '0;
                    number_next = '0;
                    seen_next   = 1'b0;
                end else if (!cls.is_skip) begin
                    mode_next = scl_pkg::MODE_ERROR;
                end
            end
            default: begin
                mode_next   = scl_pkg::MODE_DIGITS;
                count_next  = '0;
                number_next = '0;
                seen_next   = 1'b0;
            end
        endcase
    end

    // result of this byte
    always_comb begin
        event_next      = scl_pkg::EV_NONE;
        cmd_letter_next = '0;
        cmd_number_next = '0;
        present_next    = 1'b0;
        case (mode_reg)
            scl_pkg::MODE_DIGITS, scl_pkg::MODE_ERROR: begin
                if (cls.is_cr) begin
                    event_next = scl_pkg::EV_SYNTAX;
                end
            end
            scl_pkg::MODE_RETURN: begin
                if (cls.is_cr) begin
                    // classifier sees the CR, so the held letter is checked here
                    event_next      = (letter_is_known(letter_reg)) ?
                                      scl_pkg::EV_KNOWN : scl_pkg::EV_UNKNOWN;
                    cmd_letter_next = letter_reg;
                    present_next    = seen_reg;
                    cmd_number_next = seen_reg ? number_reg : 14'd0;
                end
            end
            default: begin
                event_next = scl_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= scl_pkg::MODE_DIGITS;
            count_reg    <= '0;
            number_reg   <= '0;
            seen_reg     <= 1'b0;
            letter_reg   <= '0;
            echo_reg     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                number_reg <= number_next;
                seen_reg   <= seen_next;
                letter_reg <= letter_next;
                echo_reg   <= echo_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            echo_out_reg   <= echo_reg;
            event_reg      <= event_next;
            cmd_letter_reg <= cmd_letter_next;
            cmd_number_reg <= cmd_number_next;
            present_reg    <= present_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_echo_out       = echo_out_reg;
    assign m_event_code     = event_reg;
    assign m_command_letter = cmd_letter_reg;
    assign m_command_number = cmd_number_reg;
    assign m_number_present = present_reg;

endmodule

// ----- rtl/scl_checker.sv -----
// port-level checks for the serial command line parser, bound to the top level
// depends on scl_pkg and serial_command_line_parser_macros.svh
`include "serial_command_line_parser_macros.svh"

module scl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_echo_out,
    input logic [1:0]  m_event_code,
    input logic [7:0]  m_command_letter,
    input logic [13:0] m_command_number,
    input logic        m_number_present
);

    logic        stalled;
    logic        is_command;
    logic [22:0] cmd_fields;
    logic [25:0] res_bits;

    assign stalled    = m_valid && !m_ready;
    assign is_command = (m_event_code == scl_pkg::EV_KNOWN) ||
                        (m_event_code == scl_pkg::EV_UNKNOWN);
    assign cmd_fields = {m_command_letter, m_command_number, m_number_present};
    assign res_bits   = {m_echo_out, m_event_code, cmd_fields};

    // a stalled result keeps its payload
    `SCL_ASSERT(a_hold, stalled |=> m_valid && $stable(res_bits), "stalled result changed")
    // no command fields without a command event
    `SCL_ASSERT(a_quiet, m_valid && !is_command |-> cmd_fields == '0, "fields set without command")
    // absent number reads as zero
    `SCL_ASSERT(a_absent, m_valid && !m_number_present |-> m_command_number == 14'd0, "number without digits")
    // argument stays within the decimal limit
    `SCL_ASSERT(a_limit, m_valid |-> m_command_number <= scl_pkg::NUM_LIMIT, "number above limit")
    // nothing is offered straight after reset
    `SCL_ASSERT_RST(a_reset, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (.*);

// ----- sim/scl_line_checker.sv -----
// result checker for the serial command line parser: tracks the parse state,
// predicts each result and compares it with what the block delivers
// depends on scl_pkg
`timescale 1ns / 100ps

module scl_line_checker #(
    parameter int MAX_DIGITS = scl_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_echo_out,
    input  logic [1:0]  m_event_code,
    input  logic [7:0]  m_command_letter,
    input  logic [13:0] m_command_number,
    input  logic        m_number_present,
    output int          mismatches,
    output int          outstanding,
    output int          known_count,
    output int          unknown_count,
    output int          syntax_count
);
    import scl_pkg::*;

    typedef struct packed {
        logic        echo;
        logic [1:0]  code;
        logic [7:0]  letter;
        logic [13:0] number;
        logic        present;
    } parser_result_t;

    parser_result_t pending_results[$];

    mode_t       line_mode;
    int          digit_count;
    logic [13:0] number_acc;
    logic        digit_seen;
    logic [7:0]  last_letter;
    logic        echo_on;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void restart_line();
        line_mode   = MODE_DIGITS;
        digit_count = 0;
        number_acc  = '0;
        digit_seen  = 1'b0;
    endfunction

    // advance the parse state by one byte and return the result it yields
    function automatic parser_result_t parse_byte(input logic [7:0] c);
        parser_result_t r;
        int value;
        r = '0;
        r.echo = echo_on;
        case (line_mode)
            MODE_DIGITS: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    value = number_acc * 10 + (c - CH_ZERO);
                    number_acc = (value > NUM_LIMIT) ? NUM_LIMIT : value[13:0];
                    digit_seen = 1'b1;
                    digit_count++;
                    if (digit_count >= MAX_DIGITS)
                        line_mode = MODE_LETTER;
                end else if (is_alpha(c)) begin
                    last_letter = c;
                    line_mode = MODE_RETURN;
                end else if (c == CH_LF || c == CH_SPACE) begin
                    // skipped
                end else if (c == CH_CR) begin
                    r.code = EV_SYNTAX;
                    restart_line();
                end else begin
                    line_mode = MODE_ERROR;
                end
            end
            MODE_LETTER: begin
                if (is_alpha(c)) begin
                    last_letter = c;
                    line_mode = MODE_RETURN;
                end else begin
                    line_mode = MODE_ERROR;
                end
            end
            MODE_ERROR: begin
                if (c == CH_CR) begin
                    r.code = EV_SYNTAX;
                    restart_line();
                end
            end
            default: begin
                if (c == CH_LF || c == CH_SPACE) begin
                    // skipped
                end else if (c == CH_CR) begin
                    r.letter  = last_letter;
                    r.present = digit_seen;
                    r.number  = digit_seen ? number_acc : '0;
                    case (last_letter)
                        CH_POWER, "a", "v", "V", "s", "u", "w", "c", "S", "C", CH_ECHO:
                            r.code = EV_KNOWN;
                        default:
                            r.code = EV_UNKNOWN;
                    endcase
                    if (last_letter == CH_ECHO)
                        echo_on = r.present && (r.number == 14'd1);
                    restart_line();
                end else begin
                    line_mode = MODE_ERROR;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        parser_result_t want;
        logic bad;
        if (!aresetn) begin
            restart_line();
            last_letter   = '0;
            echo_on       = 1'b0;
            pending_results.delete();
            mismatches    = 0;
            known_count   = 0;
            unknown_count = 0;
            syntax_count  = 0;
        end else begin
            // prediction first, so a result that turns up at once still finds it
            if (s_valid && s_ready)
                pending_results.push_back(parse_byte(s_rx_byte));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: echo %0d code %0d letter %02h num %0d pres %0d",
                                 $realtime, m_echo_out, m_event_code, m_command_letter,
                                 m_command_number, m_number_present);
                end else begin
                    want = pending_results.pop_front();
                    bad = (m_echo_out !== want.echo) || (m_event_code !== want.code) ||
                          (m_command_letter !== want.letter) ||
                          (m_command_number !== want.number) ||
                          (m_number_present !== want.present);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected echo %0d code %0d letter %02h num %0d pres %0d, got echo %0d code %0d letter %02h num %0d pres %0d",
                                     $realtime, want.echo, want.code, want.letter, want.number,
                                     want.present, m_echo_out, m_event_code, m_command_letter,
                                     m_command_number, m_number_present);
                    end
                    case (want.code)
                        EV_KNOWN:   known_count++;
                        EV_UNKNOWN: unknown_count++;
                        EV_SYNTAX:  syntax_count++;
                        default:    ;
                    endcase
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- sim/tb.sv -----
// testbench top for the serial command line parser: clock, reset, byte stimulus
// and handshake pressure; checking is done by scl_line_checker
// depends on scl_pkg, scl_line_checker and serial_command_line_parser
`timescale 1ns / 100ps

module tb;
    import scl_pkg::*;

    localparam int DIGITS      = MAX_DIGITS_DEFAULT;
    localparam int PHASE_BYTES = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_echo_out;
    logic [1:0]  m_event_code;
    logic [7:0]  m_command_letter;
    logic [13:0] m_command_number;
    logic        m_number_present;

    int mismatch_count;
    int results_outstanding;
    int known_count;
    int unknown_count;
    int syntax_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    logic hold_pending = 1'b0;

    serial_command_line_parser #(.MAX_DIGITS(DIGITS)) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_echo_out       (m_echo_out),
        .m_event_code     (m_event_code),
        .m_command_letter (m_command_letter),
        .m_command_number (m_command_number),
        .m_number_present (m_number_present)
    );

    scl_line_checker #(.MAX_DIGITS(DIGITS)) line_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_echo_out       (m_echo_out),
        .m_event_code     (m_event_code),
        .m_command_letter (m_command_letter),
        .m_command_number (m_command_number),
        .m_number_present (m_number_present),
        .mismatches       (mismatch_count),
        .outstanding      (results_outstanding),
        .known_count      (known_count),
        .unknown_count    (unknown_count),
        .syntax_count     (syntax_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("serial_command_line_parser: mismatch");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when asked for
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_outstanding != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] skip_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_LF;
    endfunction

    function automatic logic [7:0] any_letter();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? 8'("A" + n) : 8'("a" + n - 26);
    endfunction

    function automatic logic [7:0] command_letter();
        case ($urandom_range(0, 10))
            0:       return CH_POWER;
            1:       return "a";
            2:       return "v";
            3:       return "V";
            4:       return "s";
            5:       return "u";
            6:       return "w";
            7:       return "c";
            8:       return "S";
            9:       return "C";
            default: return CH_ECHO;
        endcase
    endfunction

    // mostly well-formed lines with random content; the rest too long,
    // broken, noisy or missing parts
    task automatic send_line();
        logic [7:0] line_bytes[$];
        int shape;
        int ndig;
        shape = $urandom_range(0, 99);
        if (shape < 10) begin
            // echo on or off, with leading zeros now and then
            repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_ZERO);
            if ($urandom_range(0, 2) != 0)
                line_bytes.push_back(8'(CH_ZERO + 1));
            else if ($urandom_range(0, 1))
                line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            line_bytes.push_back(CH_ECHO);
        end else if (shape < 13) begin
            repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            ndig = (shape < 18) ? DIGITS + 1 : $urandom_range(0, DIGITS);
            for (int i = 0; i < ndig; i++) begin
                if ($urandom_range(0, 9) == 0)
                    line_bytes.push_back(skip_char());
                line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 9) == 0)
                line_bytes.push_back(skip_char());
            // drop the letter now and then
            if (shape >= 23)
                line_bytes.push_back(($urandom_range(0, 99) < 65) ? command_letter()
                                                                   : any_letter());
            if ($urandom_range(0, 7) == 0)
                line_bytes.push_back(skip_char());
        end
        if (shape >= 30 && shape < 40)
            line_bytes.insert($urandom_range(0, line_bytes.size()),
                              8'($urandom_range(0, 255)));
        // a line left without its CR runs into the next one
        if (shape < 95 || shape >= 98)
            line_bytes.push_back(CH_CR);
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
    endtask

    initial begin
        int target;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed lines: bare CR, echo on, skipped blanks with the largest
        // number, too many digits, a bad byte, echo off, an unknown letter
        send_byte(CH_CR);
        send_text("1e");
        send_byte(CH_CR);
        send_text(" 99 99p");
        send_byte(CH_CR);
        send_text("12345");
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(8'h00);
        send_byte(CH_CR);
        send_text("e");
        send_byte(CH_CR);
        send_text("Q\n");
        send_byte(CH_CR);
        wait_drained();

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (mix == 2) begin
                // back-pressure: results held off while bytes keep coming
                hold_pending = 1'b1;
                repeat (8) send_line();
                wait_drained();
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_line();
            wait_drained();
        end
        // no CR left dangling: close any open line before the end
        send_byte(CH_CR);
        wait_drained();
        repeat (16) @(negedge aclk);

        $display("%0d bytes sent: directed lines, then random lines under four handshake mixes",
                 bytes_sent);
        $display("with a long result hold-off; %0d known, %0d unknown, %0d syntax errors seen",
                 known_count, unknown_count, syntax_count);
        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("serial_command_line_parser: match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     results_outstanding);
            $display("serial_command_line_parser: mismatch");
        end
        $finish;
    end

endmodule
